[src/salsa_pkg.sv]
`default_nettype none

package salsa_pkg;

    // Core shape
    localparam int DOUBLE_ROUNDS = 10;
    localparam int ROUND_STEPS   = 8 * DOUBLE_ROUNDS;   // 2 half rounds x 4 steps each
    localparam int CNT_W         = $clog2(ROUND_STEPS);
    localparam int WORD_W        = 32;
    localparam int NUM_WORDS     = 16;
    localparam int NUM_LANES     = 4;

    // Quarter-round rotation amounts, one per step
    localparam int ROT_0 = 7;
    localparam int ROT_1 = 9;
    localparam int ROT_2 = 13;
    localparam int ROT_3 = 18;

    // "expand 32-byte k"
    localparam logic [WORD_W-1:0] SIGMA_0 = 32'h6170_7865;
    localparam logic [WORD_W-1:0] SIGMA_1 = 32'h3320_646e;
    localparam logic [WORD_W-1:0] SIGMA_2 = 32'h7962_2d32;
    localparam logic [WORD_W-1:0] SIGMA_3 = 32'h6b20_6574;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE = 3'd4;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [3:0]        t_widx;

    // Controller -> datapath
    typedef struct packed {
        logic       accept;   // latch input item
        logic       load;     // load initial state words
        logic       rnd;      // run one step of four quarter rounds
        logic       row;      // 0: column round, 1: row round
        logic [1:0] step;     // step within the quarter round
        logic       fin;      // add initial words, advance block counter
        logic       emit;     // write output register, advance offset, or on last clear offset and counter
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic off_zero;
        logic out_free;
    } t_stat;

    // Word index of a quarter-round role (a=0, b=1, c=2, d=3) for a lane
    function automatic t_widx qr_idx(input logic row, input logic [1:0] lane,
                                     input logic [1:0] role);
        t_widx col_i;
        t_widx row_i;
        col_i = {lane, 2'b00} + {2'b00, lane} + {role, 2'b00};
        row_i = {lane, lane + role};
        return row ? row_i : col_i;
    endfunction

    // Rotate left by the constant of the given step
    function automatic t_word qr_rot(input t_word v, input logic [1:0] step);
        t_word r;
        case (step)
            2'd0:    r = (v << ROT_0) | (v >> (WORD_W - ROT_0));
            2'd1:    r = (v << ROT_1) | (v >> (WORD_W - ROT_1));
            2'd2:    r = (v << ROT_2) | (v >> (WORD_W - ROT_2));
            default: r = (v << ROT_3) | (v >> (WORD_W - ROT_3));
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[src/salsa_ctrl.sv]
`default_nettype none

module salsa_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire salsa_pkg::t_stat i_stat,
    output logic                  o_in_ready,
    output salsa_pkg::t_cmd       o_cmd
);
    import salsa_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ROUND = 2'd1;
    localparam logic [1:0] ST_FINAL = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && (r_state == ST_IDLE);

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        o_cmd        = '0;
        o_cmd.row    = r_cnt[2];
        o_cmd.step   = r_cnt[1:0];
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.accept = 1'b1;
                    n_cnt        = '0;
                    if (i_stat.off_zero) begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_ROUND;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_ROUND: begin
                o_cmd.rnd = 1'b1;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ROUND_STEPS - 1)) begin
                    n_state = ST_FINAL;
                end
            end
            ST_FINAL: begin
                o_cmd.fin = 1'b1;
                n_state   = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

[src/salsa_dp.sv]
`default_nettype none

module salsa_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire salsa_pkg::t_cmd                   i_cmd,
    output salsa_pkg::t_stat                       o_stat,
    input  wire logic                              i_cfg_valid,
    input  wire logic [salsa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [63:0]                       i_cfg_data,
    input  wire logic [7:0]                        i_in_byte,
    input  wire logic                              i_in_last,
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output logic [7:0]                             o_out_byte,
    output logic                                   o_out_last
);
    import salsa_pkg::*;

    logic [63:0] r_key [4];
    logic [63:0] n_key [4];
    logic [63:0] r_nonce, n_nonce;
    logic [63:0] r_counter, n_counter;
    logic [5:0]  r_offset, n_offset;
    t_word       r_words [NUM_WORDS];
    t_word       n_words [NUM_WORDS];
    t_word       init_w  [NUM_WORDS];
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;

    t_widx       lane_t   [NUM_LANES];
    t_word       lane_val [NUM_LANES];
    logic [7:0]  ks_byte;

    // Configuration registers
    always_comb begin
        n_key   = r_key;
        n_nonce = r_nonce;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_KEY_0: n_key[0] = i_cfg_data;
                CFG_KEY_1: n_key[1] = i_cfg_data;
                CFG_KEY_2: n_key[2] = i_cfg_data;
                CFG_KEY_3: n_key[3] = i_cfg_data;
                CFG_NONCE: n_nonce  = i_cfg_data;
                default: ;
            endcase
        end
    end

    // Initial state words
    always_comb begin
        init_w[0]  = SIGMA_0;
        init_w[1]  = r_key[0][31:0];
        init_w[2]  = r_key[0][63:32];
        init_w[3]  = r_key[1][31:0];
        init_w[4]  = r_key[1][63:32];
        init_w[5]  = SIGMA_1;
        init_w[6]  = r_nonce[31:0];
        init_w[7]  = r_nonce[63:32];
        init_w[8]  = r_counter[31:0];
        init_w[9]  = r_counter[63:32];
        init_w[10] = SIGMA_2;
        init_w[11] = r_key[2][31:0];
        init_w[12] = r_key[2][63:32];
        init_w[13] = r_key[3][31:0];
        init_w[14] = r_key[3][63:32];
        init_w[15] = SIGMA_3;
    end

    // Four quarter-round lanes, one add-rotate-xor step each per cycle
    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            lane_t[l]   = qr_idx(i_cmd.row, 2'(l), i_cmd.step + 2'd1);
            lane_val[l] = r_words[lane_t[l]]
                        ^ qr_rot(r_words[qr_idx(i_cmd.row, 2'(l), i_cmd.step)]
                               + r_words[qr_idx(i_cmd.row, 2'(l), i_cmd.step + 2'd3)],
                                 i_cmd.step);
        end
    end

    // Working words: load, round step, final add
    always_comb begin
        n_words = r_words;
        if (i_cmd.load) begin
            n_words = init_w;
        end else if (i_cmd.rnd) begin
            for (int l = 0; l < NUM_LANES; l++) begin
                n_words[lane_t[l]] = lane_val[l];
            end
        end else if (i_cmd.fin) begin
            for (int i = 0; i < NUM_WORDS; i++) begin
                n_words[i] = r_words[i] + init_w[i];
            end
        end
    end

    // Keystream byte, little-endian within each word
    assign ks_byte = r_words[r_offset[5:2]][{r_offset[1:0], 3'b000} +: 8];

    // Block counter, byte offset and output register
    always_comb begin
        n_counter   = r_counter;
        n_offset    = r_offset;
        n_out_valid = r_out_valid;
        if (i_cmd.fin) begin
            n_counter = r_counter + 64'd1;
        end
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
            if (r_in_last) begin
                n_offset  = '0;
                n_counter = '0;
            end else begin
                n_offset = r_offset + 6'd1;
            end
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key       <= '{default: '0};
            r_nonce     <= '0;
            r_counter   <= '0;
            r_offset    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_key       <= n_key;
            r_nonce     <= n_nonce;
            r_counter   <= n_counter;
            r_offset    <= n_offset;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_words <= n_words;
        if (i_cmd.accept) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
        if (i_cmd.emit) begin
            r_out_byte <= r_in_byte ^ ks_byte;
            r_out_last <= r_in_last;
        end
    end

    assign o_stat.off_zero = (r_offset == 6'd0);
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_byte      = r_out_byte;
    assign o_out_last      = r_out_last;

endmodule

`default_nettype wire

[src/salsa20_stream_xor_top.sv]
// Salsa20/20 stream XOR, one byte per item.
// A byte inside a 64-byte block goes from accept to emit; the first byte of a block first
// runs load, 80 round steps of four quarter-round lanes and the final add before emit.
// One byte is in work at a time; emit waits until the output register is free.
// The shared four-lane quarter-round unit sets the block time.
// Reset (i_rst_n low, synchronous) clears key, nonce, block counter, offset and valids.
`default_nettype none

module salsa20_stream_xor_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,     // [7:0] data_byte
    input  wire logic        s_axis_tlast,     // last_of_message
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,     // [7:0] out_byte
    output logic             m_axis_tlast,     // out_last
    // configuration writes
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [salsa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [63:0]                       i_cfg_data
);
    import salsa_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Registers are written whenever presented
    assign o_cfg_ready = 1'b1;

    salsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_stat     (stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    salsa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_byte   (s_axis_tdata),
        .i_in_last   (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_byte  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

[src/salsa_chk.sv]
`default_nettype none

module salsa_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [7:0]  m_axis_tdata,
    input wire logic        m_axis_tlast
);

    // Output valid holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    // Output item holds while stalled
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output item changed while stalled");

    // One item in work at a time: input closes after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted back to back");

    // A new result only appears while the input side is busy
    a_out_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without an item in work");

    // Reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind salsa20_stream_xor_top salsa_chk u_salsa_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

[tb/salsa20_stream_xor_top_test.sv]
`timescale 1ns / 100ps

module salsa20_stream_xor_top_test;

    import salsa_pkg::*;

    localparam int HALF_PERIOD = 5;
    localparam int RST_CYCLES  = 12;
    localparam int NUM_PHASES  = 10;
    localparam int PHASE_ITEMS = 110;
    localparam int DRAIN_WAIT  = 100;    // covers the block-opening latency
    localparam int STALL_LIMIT = 3000;   // cycles with no handshake on any channel

    // One byte item, in or out
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_of_message;
    } t_xor_item;

    // Clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #HALF_PERIOD i_clk = ~i_clk;

    // Block ports
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = 8'h00;   // [7:0] data_byte
    logic                 s_axis_tlast  = 1'b0;    // last_of_message
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;            // [7:0] out_byte
    logic                 m_axis_tlast;            // out_last
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = CFG_KEY_0;
    logic [63:0]          i_cfg_data    = 64'd0;

    salsa20_stream_xor_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Cipher model state
    logic [63:0] key_q [4];
    logic [63:0] nonce_q;
    logic [63:0] blk_ctr;
    logic [5:0]  ks_off;
    logic [7:0]  ks_bytes [64];
    logic [31:0] mix_w [16];

    // Expected output bytes, oldest first
    t_xor_item cipher_q [$];

    // Run bookkeeping
    int  err_cnt    = 0;
    int  n_in       = 0;
    int  n_out      = 0;
    int  n_msgs     = 0;
    int  n_blocks   = 0;
    int  n_cfg      = 0;
    int  n_drains   = 0;
    int  rx_wait    = 0;
    int  idle_cyc   = 0;
    bit  tx_idle_en = 1'b0;
    bit  rx_idle_en = 1'b0;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void quarter(input int a, input int b, input int c, input int d);
        mix_w[b] = mix_w[b] ^ rotl(mix_w[a] + mix_w[d], ROT_0);
        mix_w[c] = mix_w[c] ^ rotl(mix_w[b] + mix_w[a], ROT_1);
        mix_w[d] = mix_w[d] ^ rotl(mix_w[c] + mix_w[b], ROT_2);
        mix_w[a] = mix_w[a] ^ rotl(mix_w[d] + mix_w[c], ROT_3);
    endfunction

    // Generate the 64-byte keystream block for the current counter
    function automatic void refill_keystream();
        logic [31:0] init_w [16];
        logic [31:0] v;
        init_w[0]  = SIGMA_0;
        init_w[1]  = key_q[0][31:0];
        init_w[2]  = key_q[0][63:32];
        init_w[3]  = key_q[1][31:0];
        init_w[4]  = key_q[1][63:32];
        init_w[5]  = SIGMA_1;
        init_w[6]  = nonce_q[31:0];
        init_w[7]  = nonce_q[63:32];
        init_w[8]  = blk_ctr[31:0];
        init_w[9]  = blk_ctr[63:32];
        init_w[10] = SIGMA_2;
        init_w[11] = key_q[2][31:0];
        init_w[12] = key_q[2][63:32];
        init_w[13] = key_q[3][31:0];
        init_w[14] = key_q[3][63:32];
        init_w[15] = SIGMA_3;
        for (int i = 0; i < 16; i++) mix_w[i] = init_w[i];
        for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
            // column round
            quarter(0, 4, 8, 12);
            quarter(5, 9, 13, 1);
            quarter(10, 14, 2, 6);
            quarter(15, 3, 7, 11);
            // row round
            quarter(0, 1, 2, 3);
            quarter(5, 6, 7, 4);
            quarter(10, 11, 8, 9);
            quarter(15, 12, 13, 14);
        end
        for (int i = 0; i < 16; i++) begin
            v = mix_w[i] + init_w[i];
            for (int j = 0; j < 4; j++) ks_bytes[4 * i + j] = v[8 * j +: 8];
        end
    endfunction

    // XOR one byte with keystream and advance offset / counter
    function automatic t_xor_item xor_keystream(input logic [7:0] d, input logic l);
        t_xor_item r;
        if (ks_off == 6'd0) begin
            refill_keystream();
            blk_ctr = blk_ctr + 64'd1;
            n_blocks++;
        end
        r.data_byte       = d ^ ks_bytes[ks_off];
        r.last_of_message = l;
        if (l) begin
            ks_off  = 6'd0;
            blk_ctr = 64'd0;
            n_msgs++;
        end else begin
            ks_off = ks_off + 6'd1;
        end
        return r;
    endfunction

    function automatic void reset_cipher();
        for (int i = 0; i < 4; i++) key_q[i] = 64'd0;
        for (int i = 0; i < 64; i++) ks_bytes[i] = 8'd0;
        nonce_q = 64'd0;
        blk_ctr = 64'd0;
        ks_off  = 6'd0;
    endfunction

    // Send one byte; expectation is queued before the handshake
    task automatic send_byte(input logic [7:0] d, input logic l);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cipher_q.push_back(xor_keystream(d, l));
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tlast  <= l;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        n_in++;
    endtask

    // Stop sending and wait for every expected byte
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (cipher_q.size() != 0) @(posedge i_clk);
        n_drains++;
    endtask

    // Register write; valid stays high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_KEY_0: key_q[0] = val;
            CFG_KEY_1: key_q[1] = val;
            CFG_KEY_2: key_q[2] = val;
            CFG_KEY_3: key_q[3] = val;
            CFG_NONCE: nonce_q  = val;
            default: ;
        endcase
        n_cfg++;
    endtask

    // Output side: random backpressure, compare against oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait       <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            t_xor_item got;
            t_xor_item want;
            got.data_byte       = m_axis_tdata;
            got.last_of_message = m_axis_tlast;
            n_out++;
            if (cipher_q.size() == 0) begin
                $display("%0t: unexpected item out_byte %02h out_last %0b", $time,
                         got.data_byte, got.last_of_message);
                err_cnt++;
            end else begin
                want = cipher_q.pop_front();
                if (got.data_byte !== want.data_byte) begin
                    $display("%0t: out_byte mismatch expected %02h actual %02h", $time,
                             want.data_byte, got.data_byte);
                    err_cnt++;
                end
                if (got.last_of_message !== want.last_of_message) begin
                    $display("%0t: out_last mismatch expected %0b actual %0b", $time,
                             want.last_of_message, got.last_of_message);
                    err_cnt++;
                end
            end
            if (rx_idle_en && $urandom_range(0, 7) != 0) begin
                m_axis_tready <= 1'b0;
                rx_wait       <= $urandom_range(0, 6);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end else if (!m_axis_tready) begin
            if (rx_wait == 0) m_axis_tready <= 1'b1;
            else rx_wait <= rx_wait - 1;
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cyc <= 0;
        end else if (i_rst_n) begin
            idle_cyc <= idle_cyc + 1;
            if (idle_cyc + 1 >= STALL_LIMIT) begin
                $display("%0t: timeout, no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Directed items under the reset key and nonce: single-byte messages,
    // data extremes, single-bit patterns and short multi-byte messages
    t_xor_item dir_tbl [] = '{
        '{8'h00, 1'b1}, '{8'hff, 1'b1}, '{8'h00, 1'b0}, '{8'hff, 1'b0},
        '{8'h01, 1'b0}, '{8'h80, 1'b0}, '{8'h7f, 1'b1}, '{8'h55, 1'b1},
        '{8'haa, 1'b0}, '{8'h0f, 1'b0}, '{8'hf0, 1'b1}, '{8'h00, 1'b0},
        '{8'h02, 1'b0}, '{8'h04, 1'b0}, '{8'h08, 1'b0}, '{8'h10, 1'b0},
        '{8'h20, 1'b0}, '{8'h40, 1'b0}, '{8'hfe, 1'b0}, '{8'hc3, 1'b0},
        '{8'h3c, 1'b1}
    };

    initial begin
        int msg_left;
        int sel;
        logic [63:0] val;

        reset_cipher();
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, back to back then with gaps
        foreach (dir_tbl[i]) begin
            tx_idle_en = (i >= 11);
            rx_idle_en = (i >= 11);
            send_byte(dir_tbl[i].data_byte, dir_tbl[i].last_of_message);
        end
        drain();

        // Random phases; a phase may end mid-message, so the new settings
        // also land in the middle of a block
        msg_left = 0;
        for (int p = 1; p < NUM_PHASES; p++) begin
            drain();
            for (int r = 0; r < 5; r++) begin
                case (p)
                    1:       val = '1;
                    2:       val = '0;
                    3:       val = r[0] ? 64'h5555_5555_5555_5555 : 64'haaaa_aaaa_aaaa_aaaa;
                    default: val = {$urandom(), $urandom()};
                endcase
                if (p <= 3 || r == p % 5 || $urandom_range(0, 1) == 1)
                    write_reg(CFG_IDX_W'(r), val);
            end
            i_cfg_valid <= 1'b0;
            tx_idle_en = (p % 4 != 1);
            rx_idle_en = (p % 3 != 2);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (msg_left == 0) begin
                    sel = $urandom_range(0, 9);
                    if (sel < 6)      msg_left = $urandom_range(1, 16);
                    else if (sel < 9) msg_left = $urandom_range(17, 130);
                    else              msg_left = $urandom_range(131, 260);
                end
                if ($urandom_range(0, 63) == 0) drain();
                msg_left--;
                send_byte(8'($urandom_range(0, 255)), msg_left == 0);
            end
        end

        drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d items in %0d complete messages, %0d keystream blocks.",
                 n_in, n_msgs, n_blocks);
        $display("Checked %0d output items across %0d register writes and %0d drains.",
                 n_out, n_cfg, n_drains);
        if (err_cnt == 0 && cipher_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d expected items never seen", err_cnt,
                     cipher_q.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
